// File: rtl/optf_pkg.sv
// shared types and constants of the overlay peer table forwarder
`default_nettype none
package optf_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ADDR_W = 48;
    localparam int MAC_W = 48;
    localparam int COMM_W = 64;
    localparam int SOCK_W = 8;
    localparam int TTL_W = 8;
    localparam int VER_W = 8;
    localparam int LEN_W = 11;
    localparam int COPIES_W = 6;
    localparam int CFG_DATA_W = 11;
    localparam int MCAST_BIT = 40;

    localparam logic [1:0] FUNC_REG = 2'd0;
    localparam logic [1:0] FUNC_DEREG = 2'd1;
    localparam logic [1:0] FUNC_DATA = 2'd2;
    localparam logic [1:0] FUNC_OTHER = 2'd3;

    localparam logic CFG_EXPECTED_VERSION = 1'b0;
    localparam logic CFG_MIN_HEADER_LEN = 1'b1;

    typedef enum logic [2:0] {
        KIND_ACK = 3'd0,
        KIND_UNI = 3'd1,
        KIND_BC = 3'd2,
        KIND_DROP = 3'd3,
        KIND_DONE = 3'd4,
        KIND_FULL = 3'd5,
        KIND_MISS = 3'd6,
        KIND_DEREG = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_SCAN,
        ST_ACK,
        ST_FULL,
        ST_DRES,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [COMM_W-1:0]   comm_hi;
        logic [COMM_W-1:0]   comm_lo;
        logic [MAC_W-1:0]    mac;
        logic [ADDR_W-1:0]   pub_addr;
        logic [ADDR_W-1:0]   priv_addr;
        logic [SOCK_W-1:0]   sock;
    } entry_t;

endpackage
`default_nettype wire

// File: rtl/optf_cell.sv
// one table slot of the rotating peer table
`default_nettype none
module optf_cell
    import optf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire entry_t d,
    output entry_t      q
);

    logic   valid_reg;
    entry_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    always_comb
    begin
        q = data_reg;
        q.valid = valid_reg;
    end

endmodule
`default_nettype wire

// File: rtl/optf_chain.sv
// ring of slot cells, each hands its entry to the next one down on every shift
`default_nettype none
module optf_chain
    import optf_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire entry_t tail_in,
    output entry_t      head
);

    entry_t q [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == DEPTH - 1)
            begin : g_tail
                optf_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (tail_in),
                    .q     (q[g])
                );
            end
            else
            begin : g_body
                optf_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (q[g+1]),
                    .q     (q[g])
                );
            end
        end
    endgenerate

    assign head = q[0];

endmodule
`default_nettype wire

// File: rtl/overlay_peer_table_forwarder.sv
// top level: header checks, table scan and result sequencing
`default_nettype none
// Takes one parsed header per item and produces its results on the output
// channel. The peer table sits in a ring of DEPTH cells that rotates one slot
// per cycle past a single compare point at its head, except while the output
// side stalls a copy during the second rotation. A discarded item only gets
// its drop result; any other item is accepted, takes one lookup rotation and
// then produces its results. Register items that find their entry or a free
// slot, deregister hits and data items then take a second rotation in which
// the table is updated and copies are sent in slot order.
// A new item is taken once the previous one is finished.
module overlay_peer_table_forwarder
    import optf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            func,
    input  wire logic [VER_W-1:0]      version,
    input  wire logic [LEN_W-1:0]      pkt_len,
    input  wire logic [COMM_W-1:0]     community_hi,
    input  wire logic [COMM_W-1:0]     community_lo,
    input  wire logic [MAC_W-1:0]      src_mac,
    input  wire logic [MAC_W-1:0]      dst_mac,
    input  wire logic [ADDR_W-1:0]     sender_addr,
    input  wire logic [ADDR_W-1:0]     private_addr,
    input  wire logic [SOCK_W-1:0]     socket_tag,
    input  wire logic [TTL_W-1:0]      ttl_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [2:0]                 kind,
    output logic [ADDR_W-1:0]          dest_addr,
    output logic [SOCK_W-1:0]          dest_socket,
    output logic [MAC_W-1:0]           ack_mac,
    output logic [TTL_W-1:0]           ttl_out,
    output logic [COPIES_W-1:0]        copies,
    output logic                       last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] IDX_END = CNT_W'(TABLE_DEPTH - 1);

    // configuration
    logic [VER_W-1:0] exp_ver_reg;
    logic [LEN_W-1:0] min_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_ver_reg <= VER_W'(1);
            min_len_reg <= LEN_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_VERSION: exp_ver_reg <= cfg_data[VER_W-1:0];
                CFG_MIN_HEADER_LEN:   min_len_reg <= cfg_data[LEN_W-1:0];
                default:              ;
            endcase
        end
    end

    // latched item
    logic [1:0]        func_reg;
    logic [COMM_W-1:0] chi_reg;
    logic [COMM_W-1:0] clo_reg;
    logic [MAC_W-1:0]  smac_reg;
    logic [MAC_W-1:0]  dmac_reg;
    logic [ADDR_W-1:0] sender_reg;
    logic [ADDR_W-1:0] priv_reg;
    logic [SOCK_W-1:0] sock_reg;
    logic [TTL_W-1:0]  ttl_reg;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg   <= func;
            chi_reg    <= community_hi;
            clo_reg    <= community_lo;
            smac_reg   <= src_mac;
            dmac_reg   <= dst_mac;
            sender_reg <= sender_addr;
            priv_reg   <= private_addr;
            sock_reg   <= socket_tag;
            ttl_reg    <= ttl_in + TTL_W'(1);
        end
    end

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                m_found_reg, m_found_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic                f_found_reg, f_found_next;
    logic [IDX_W-1:0]    f_idx_reg, f_idx_next;
    logic                u_found_reg, u_found_next;
    logic [IDX_W-1:0]    u_idx_reg, u_idx_next;
    logic [COPIES_W-1:0] cnt_reg, cnt_next;

    // output register
    logic                out_valid_reg;
    kind_t               kind_reg;
    logic [ADDR_W-1:0]   dest_reg;
    logic [SOCK_W-1:0]   dsock_reg;
    logic [MAC_W-1:0]    amac_reg;
    logic [TTL_W-1:0]    ttlo_reg;
    logic [COPIES_W-1:0] copies_reg;
    logic                last_reg;

    logic                ld;
    kind_t               ld_kind;
    logic [ADDR_W-1:0]   ld_dest;
    logic [SOCK_W-1:0]   ld_sock;
    logic [MAC_W-1:0]    ld_amac;
    logic [TTL_W-1:0]    ld_ttl;
    logic [COPIES_W-1:0] ld_copies;
    logic                ld_last;

    logic   shift;
    entry_t head;
    entry_t head_new;

    optf_chain #(
        .DEPTH (TABLE_DEPTH)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .tail_in (head_new),
        .head    (head)
    );

    logic [IDX_W-1:0] pos;
    logic             out_free;
    logic             drop;
    logic             key_hit;
    logic             comm_hit;
    logic             emit;
    logic             emit_uni;

    assign pos      = idx_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || out_ready;
    assign drop     = (pkt_len < min_len_reg) || (version != exp_ver_reg) ||
                      (func == FUNC_OTHER);
    assign comm_hit = head.valid && (head.comm_hi == chi_reg) && (head.comm_lo == clo_reg);
    assign key_hit  = comm_hit && (head.mac == smac_reg);
    assign emit_uni = u_found_reg && (pos == u_idx_reg);
    assign emit     = (func_reg == FUNC_DATA) &&
                      (u_found_reg ? emit_uni : (comm_hit && (head.pub_addr != sender_reg)));
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_found_next = m_found_reg;
        m_idx_next   = m_idx_reg;
        f_found_next = f_found_reg;
        f_idx_next   = f_idx_reg;
        u_found_next = u_found_reg;
        u_idx_next   = u_idx_reg;
        cnt_next     = cnt_reg;
        shift        = 1'b0;
        head_new     = head;
        ld           = 1'b0;
        ld_kind      = KIND_DROP;
        ld_dest      = '0;
        ld_sock      = '0;
        ld_amac      = '0;
        ld_ttl       = '0;
        ld_copies    = '0;
        ld_last      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = drop ? ST_DROP : ST_SCAN;
                    idx_next     = '0;
                    m_found_next = 1'b0;
                    f_found_next = 1'b0;
                    u_found_next = 1'b0;
                    cnt_next     = '0;
                end
            end
            ST_DROP:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_DROP;
                    ld_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                shift = 1'b1;
                if (!m_found_reg && key_hit)
                begin
                    m_found_next = 1'b1;
                    m_idx_next   = pos;
                end
                if (!f_found_reg && !head.valid)
                begin
                    f_found_next = 1'b1;
                    f_idx_next   = pos;
                end
                if (!u_found_reg && head.valid && !dmac_reg[MCAST_BIT] &&
                    (head.mac == dmac_reg))
                begin
                    u_found_next = 1'b1;
                    u_idx_next   = pos;
                end
                if (idx_reg == IDX_END)
                begin
                    idx_next = '0;
                    case (func_reg)
                        FUNC_REG:   state_next = ST_ACK;
                        FUNC_DEREG: state_next = ST_DRES;
                        default:    state_next = ST_WALK;
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_ACK;
                    ld_dest    = sender_reg;
                    ld_sock    = sock_reg;
                    ld_amac    = smac_reg;
                    ld_last    = m_found_reg || f_found_reg;
                    state_next = (m_found_reg || f_found_reg) ? ST_WALK : ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_FULL;
                    ld_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DRES:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_kind    = m_found_reg ? KIND_DEREG : KIND_MISS;
                    ld_last    = 1'b1;
                    state_next = m_found_reg ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (!emit || out_free)
                begin
                    shift = 1'b1;
                    // table updates happen as the target slot passes the head
                    if (func_reg == FUNC_REG)
                    begin
                        if (m_found_reg && (pos == m_idx_reg))
                        begin
                            head_new.pub_addr  = sender_reg;
                            head_new.priv_addr = priv_reg;
                        end
                        else if (!m_found_reg && (pos == f_idx_reg))
                        begin
                            head_new.valid     = 1'b1;
                            head_new.comm_hi   = chi_reg;
                            head_new.comm_lo   = clo_reg;
                            head_new.mac       = smac_reg;
                            head_new.pub_addr  = sender_reg;
                            head_new.priv_addr = priv_reg;
                            head_new.sock      = sock_reg;
                        end
                    end
                    else if ((func_reg == FUNC_DEREG) && (pos == m_idx_reg))
                    begin
                        head_new.valid = 1'b0;
                    end
                    if (emit)
                    begin
                        ld       = 1'b1;
                        ld_kind  = emit_uni ? KIND_UNI : KIND_BC;
                        ld_dest  = head.pub_addr;
                        ld_sock  = head.sock;
                        ld_ttl   = ttl_reg;
                        cnt_next = cnt_reg + COPIES_W'(1);
                    end
                    if (idx_reg == IDX_END)
                    begin
                        idx_next   = '0;
                        state_next = (func_reg == FUNC_DATA) ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_DONE;
                    ld_copies  = cnt_reg;
                    ld_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            m_found_reg   <= 1'b0;
            f_found_reg   <= 1'b0;
            u_found_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_found_reg <= m_found_next;
            f_found_reg <= f_found_next;
            u_found_reg <= u_found_next;
            cnt_reg     <= cnt_next;
            if (ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_idx_reg <= m_idx_next;
        f_idx_reg <= f_idx_next;
        u_idx_reg <= u_idx_next;
        if (ld)
        begin
            kind_reg   <= ld_kind;
            dest_reg   <= ld_dest;
            dsock_reg  <= ld_sock;
            amac_reg   <= ld_amac;
            ttlo_reg   <= ld_ttl;
            copies_reg <= ld_copies;
            last_reg   <= ld_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign dest_addr   = dest_reg;
    assign dest_socket = dsock_reg;
    assign ack_mac     = amac_reg;
    assign ttl_out     = ttlo_reg;
    assign copies      = copies_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_END)
        else $error("slot index ran past the table");

    a_copies_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DONE) |-> copies <= COPIES_W'(TABLE_DEPTH))
        else $error("copy count above table depth");

    a_uni_found: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && (kind == KIND_UNI) |-> u_found_reg)
        else $error("unicast copy without a lookup hit");
`endif

endmodule
`default_nettype wire
